/* design/sha1_pkg.sv */
// ============================================================================
// sha1_pkg
// Shared types and constants for the SHA-1 byte stream hasher: the command
// codes, the sequencer states, the round constants and the initial words.
// ============================================================================
package sha1_pkg;

    // Command codes carried on the input tuser field.
    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;

    // Block geometry and round count.
    localparam int unsigned BLOCK_BITS  = 512;
    localparam int unsigned ROUND_COUNT = 80;
    localparam int unsigned DIGEST_LAST = 4;

    // Padding values.
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [7:0] PAD_ZERO     = 8'h00;
    localparam logic [5:0] LENGTH_START = 6'd56;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_GROUP0 = 32'h5A827999;
    localparam logic [31:0] K_GROUP1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GROUP2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GROUP3 = 32'hCA62C1D6;

    // Initial chaining words.
    localparam logic [31:0] IV_WORD0 = 32'h67452301;
    localparam logic [31:0] IV_WORD1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_WORD2 = 32'h98BADCFE;
    localparam logic [31:0] IV_WORD3 = 32'h10325476;
    localparam logic [31:0] IV_WORD4 = 32'hC3D2E1F0;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } sha1_state_t;

endpackage

/* design/sha1_byte_stream_hasher_unit.sv */
// ============================================================================
// sha1_byte_stream_hasher_unit
// SHA-1 hasher that takes a message one byte per word and returns the
// 160-bit digest as five 32-bit words, most significant word first.
// ============================================================================
// The input takes one byte per cycle while the block buffer is filling. The
// byte that completes a 64-byte block starts a compression: 80 rounds, one
// per cycle on the single shared round datapath, then an add of the working
// words into the chaining words. The input is not ready while a block is
// being compressed. A finish command pushes the padding bytes and the length
// one per cycle through the same byte path, except while a block is
// compressed (up to 72 bytes, plus one or two compressions), then presents
// the five digest words; the next message may start once the fifth word is
// taken. The 64-byte buffer is the 512-bit message schedule shift line
// itself, so no memory is used.
module sha1_byte_stream_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Digest stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    localparam int unsigned BB = sha1_pkg::BLOCK_BITS;

    // Registers.
    sha1_pkg::sha1_state_t state_reg, state_next;
    sha1_pkg::sha1_state_t ret_reg, ret_next;
    logic [31:0]   chain_reg [5];
    logic [31:0]   chain_next [5];
    logic [BB-1:0] blk_reg, blk_next;
    logic [5:0]    fill_reg, fill_next;
    logic [60:0]   total_reg, total_next;
    logic [6:0]    rnd_reg, rnd_next;
    logic [2:0]    idx_reg, idx_next;
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]   a_next, b_next, c_next, d_next, e_next;

    // Control decode.
    logic        in_accept;
    logic        out_accept;
    logic        push_en;
    logic [7:0]  push_byte;
    logic        count_en;
    logic        block_full;
    logic        load_work;
    logic        digest_done;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;

    // Round datapath.
    logic [31:0] w0, w2, w8, w13, wx, wnew;
    logic [31:0] f_val, k_val, t_val;

    assign in_accept   = s_tvalid && s_tready;
    assign out_accept  = m_tvalid && m_tready;
    assign block_full  = (fill_reg == 6'd63);
    assign digest_done = out_accept && (idx_reg == 3'(sha1_pkg::DIGEST_LAST));

    // Length byte for the current fill position, most significant first.
    assign len_bits = {total_reg, 3'b000};
    assign len_byte = 8'(len_bits >> {~fill_reg[2:0], 3'b000});

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            sha1_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        sha1_pkg::CMD_ABSORB: begin
                            if (block_full) begin
                                state_next = sha1_pkg::ST_ROUND;
                                ret_next   = sha1_pkg::ST_IDLE;
                            end
                        end
                        sha1_pkg::CMD_ABSORB_FINISH: begin
                            if (block_full) begin
                                state_next = sha1_pkg::ST_ROUND;
                                ret_next   = sha1_pkg::ST_MARK;
                            end else begin
                                state_next = sha1_pkg::ST_MARK;
                            end
                        end
                        sha1_pkg::CMD_FINISH: begin
                            state_next = sha1_pkg::ST_MARK;
                        end
                        default: begin
                            state_next = sha1_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sha1_pkg::ST_ROUND: begin
                if (rnd_reg == 7'(sha1_pkg::ROUND_COUNT - 1)) begin
                    state_next = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD: begin
                state_next = ret_reg;
            end
            sha1_pkg::ST_MARK: begin
                if (block_full) begin
                    state_next = sha1_pkg::ST_ROUND;
                    ret_next   = sha1_pkg::ST_ZERO;
                end else begin
                    state_next = sha1_pkg::ST_ZERO;
                end
            end
            sha1_pkg::ST_ZERO: begin
                if (fill_reg == sha1_pkg::LENGTH_START) begin
                    state_next = sha1_pkg::ST_LEN;
                end else if (block_full) begin
                    state_next = sha1_pkg::ST_ROUND;
                    ret_next   = sha1_pkg::ST_ZERO;
                end
            end
            sha1_pkg::ST_LEN: begin
                if (block_full) begin
                    state_next = sha1_pkg::ST_ROUND;
                    ret_next   = sha1_pkg::ST_OUT;
                end
            end
            sha1_pkg::ST_OUT: begin
                if (digest_done) begin
                    state_next = sha1_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and control decode of the sequencer.
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        push_en   = 1'b0;
        push_byte = sha1_pkg::PAD_ZERO;
        count_en  = 1'b0;
        case (state_reg)
            sha1_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                push_byte = s_tdata;
                if (in_accept && (s_tuser == sha1_pkg::CMD_ABSORB ||
                                  s_tuser == sha1_pkg::CMD_ABSORB_FINISH)) begin
                    push_en  = 1'b1;
                    count_en = 1'b1;
                end
            end
            sha1_pkg::ST_MARK: begin
                push_en   = 1'b1;
                push_byte = sha1_pkg::PAD_MARK;
            end
            sha1_pkg::ST_ZERO: begin
                push_en   = (fill_reg != sha1_pkg::LENGTH_START);
                push_byte = sha1_pkg::PAD_ZERO;
            end
            sha1_pkg::ST_LEN: begin
                push_en   = 1'b1;
                push_byte = len_byte;
            end
            sha1_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    assign load_work = push_en && block_full;

    // Schedule taps and round function.
    assign w0   = blk_reg[BB-1 -: 32];
    assign w2   = blk_reg[BB-1-64 -: 32];
    assign w8   = blk_reg[BB-1-256 -: 32];
    assign w13  = blk_reg[BB-1-416 -: 32];
    assign wx   = w13 ^ w8 ^ w2 ^ w0;
    assign wnew = {wx[30:0], wx[31]};

    always_comb begin
        case (rnd_reg) inside
            [7'd0:7'd19]: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1_pkg::K_GROUP0;
            end
            [7'd20:7'd39]: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_GROUP1;
            end
            [7'd40:7'd59]: begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1_pkg::K_GROUP2;
            end
            default: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_GROUP3;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    // Datapath next values.
    always_comb begin
        blk_next   = blk_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        for (int i = 0; i < 5; i++) begin
            chain_next[i] = chain_reg[i];
        end

        // Byte path into the block shift line.
        if (push_en) begin
            blk_next  = {blk_reg[BB-9:0], push_byte};
            fill_next = fill_reg + 6'd1;
        end
        if (count_en) begin
            total_next = total_reg + 61'd1;
        end

        // A full block loads the working words and starts the rounds.
        if (load_work) begin
            a_next   = chain_reg[0];
            b_next   = chain_reg[1];
            c_next   = chain_reg[2];
            d_next   = chain_reg[3];
            e_next   = chain_reg[4];
            rnd_next = 7'd0;
        end

        // One round per cycle; the schedule shifts by one word.
        if (state_reg == sha1_pkg::ST_ROUND) begin
            a_next   = t_val;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
            blk_next = {blk_reg[BB-33:0], wnew};
            rnd_next = rnd_reg + 7'd1;
        end

        // Fold the working words into the chaining words.
        if (state_reg == sha1_pkg::ST_ADD) begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end

        // Digest words go out one at a time; the last restarts the message.
        if (out_accept) begin
            idx_next = idx_reg + 3'd1;
        end
        if (digest_done) begin
            idx_next      = 3'd0;
            fill_next     = 6'd0;
            total_next    = 61'd0;
            chain_next[0] = sha1_pkg::IV_WORD0;
            chain_next[1] = sha1_pkg::IV_WORD1;
            chain_next[2] = sha1_pkg::IV_WORD2;
            chain_next[3] = sha1_pkg::IV_WORD3;
            chain_next[4] = sha1_pkg::IV_WORD4;
        end
    end

    // Control and chaining registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1_pkg::ST_IDLE;
            ret_reg      <= sha1_pkg::ST_IDLE;
            fill_reg     <= 6'd0;
            total_reg    <= 61'd0;
            rnd_reg      <= 7'd0;
            idx_reg      <= 3'd0;
            chain_reg[0] <= sha1_pkg::IV_WORD0;
            chain_reg[1] <= sha1_pkg::IV_WORD1;
            chain_reg[2] <= sha1_pkg::IV_WORD2;
            chain_reg[3] <= sha1_pkg::IV_WORD3;
            chain_reg[4] <= sha1_pkg::IV_WORD4;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // Working words and block shift line.
    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    // Digest word select.
    always_comb begin
        case (idx_reg)
            3'd0:    m_tdata = chain_reg[0];
            3'd1:    m_tdata = chain_reg[1];
            3'd2:    m_tdata = chain_reg[2];
            3'd3:    m_tdata = chain_reg[3];
            default: m_tdata = chain_reg[4];
        endcase
    end

    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == 3'(sha1_pkg::DIGEST_LAST));

    // Input and digest sides are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a digest word is presented");

    // The eightieth round is always followed by the chaining add.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha1_pkg::ST_ROUND &&
         rnd_reg == 7'(sha1_pkg::ROUND_COUNT - 1)) |=>
        (state_reg == sha1_pkg::ST_ADD))
        else $error("round sequence did not end in the chaining add");

    // The block buffer is empty while a compression runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha1_pkg::ST_ROUND) |-> (fill_reg == 6'd0))
        else $error("fill count not cleared during compression");

    // A taken digest word other than the last is followed by the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest words out of sequence");

endmodule

/* dv/sha1_checker.sv */
// ============================================================================
// sha1_checker
// Watches both streams of the SHA-1 hasher. It keeps its own copy of the
// chaining words, block buffer and length count, and predicts the five digest
// words of every finished message. It compares each digest word taken from
// the block with the oldest prediction and counts the mismatches.
// ============================================================================
module sha1_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] digest_word
    input  logic [2:0]  m_tuser,   // [2:0] word_index
    input  logic        m_tlast,   // last_word
    output int          mismatch_count,
    output int          digests_owed,
    output int          words_checked,
    output int          messages_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // Predicted digest words, oldest first.
    digest_word_t digest_q[$];
    digest_word_t want;

    // Hash state of the message in progress.
    logic [31:0] chain [5];
    logic [7:0]  block_bytes [64];
    int unsigned fill;
    logic [60:0] byte_total;

    int bad_words = 0;
    int seen_words = 0;
    int seen_messages = 0;
    int owed_words = 0;

    assign mismatch_count  = bad_words;
    assign digests_owed    = owed_words;
    assign words_checked   = seen_words;
    assign messages_closed = seen_messages;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Start a new message from the initial chaining words.
    task automatic restart();
        chain[0]   = sha1_pkg::IV_WORD0;
        chain[1]   = sha1_pkg::IV_WORD1;
        chain[2]   = sha1_pkg::IV_WORD2;
        chain[3]   = sha1_pkg::IV_WORD3;
        chain[4]   = sha1_pkg::IV_WORD4;
        fill       = 0;
        byte_total = '0;
    endtask

    // Run the 80 rounds over the buffered block and fold them into the chain.
    task automatic hash_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int unsigned slot;
        for (int r = 0; r < 16; r++) begin
            w[r] = {block_bytes[4*r], block_bytes[4*r+1],
                    block_bytes[4*r+2], block_bytes[4*r+3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            slot = r % 16;
            // The schedule rolls through a window of sixteen words.
            if (r >= 16) begin
                w[slot] = rotl(w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[slot], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_GROUP0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_GROUP1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_GROUP2;
            end else begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_GROUP3;
            end
            t = rotl(a, 5) + f + e + k + w[slot];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    // Put one byte in the buffer and compress once a block is full.
    task automatic push_byte(input logic [7:0] value);
        block_bytes[fill] = value;
        fill++;
        if (fill == 64) begin
            hash_block();
            fill = 0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] value);
        byte_total++;
        push_byte(value);
    endtask

    // Pad, append the bit length and queue the five digest words.
    task automatic close_message();
        logic [63:0]  bit_len;
        digest_word_t dw;
        bit_len = {byte_total, 3'b000};
        push_byte(sha1_pkg::PAD_MARK);
        while (fill != sha1_pkg::LENGTH_START) begin
            push_byte(sha1_pkg::PAD_ZERO);
        end
        for (int i = 7; i >= 0; i--) begin
            push_byte(bit_len[8*i +: 8]);
        end
        for (int i = 0; i < 5; i++) begin
            dw.word  = chain[i];
            dw.index = 3'(i);
            dw.last  = (i == sha1_pkg::DIGEST_LAST);
            digest_q.push_back(dw);
        end
        seen_messages++;
        restart();
    endtask

    // Follow every accepted input word and check every digest word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            digest_q.delete();
            restart();
            owed_words = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    sha1_pkg::CMD_ABSORB: begin
                        absorb_byte(s_tdata);
                    end
                    sha1_pkg::CMD_ABSORB_FINISH: begin
                        absorb_byte(s_tdata);
                        close_message();
                    end
                    sha1_pkg::CMD_FINISH: begin
                        close_message();
                    end
                    default: begin
                        // The unused command leaves the hash untouched.
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen_words++;
                if (digest_q.size() == 0) begin
                    bad_words++;
                    if (bad_words <= REPORT_LIMIT) begin
                        $display("%0t: digest word %h index %0d last %0b arrived with none due",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want = digest_q.pop_front();
                    if (m_tdata !== want.word || m_tuser !== want.index ||
                        m_tlast !== want.last) begin
                        bad_words++;
                        if (bad_words <= REPORT_LIMIT) begin
                            $display("%0t: digest word differs: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     $realtime, want.word, want.index, want.last,
                                     m_tdata, m_tuser, m_tlast);
                        end
                    end
                end
            end
            owed_words = digest_q.size();
        end
    end

endmodule

/* dv/tb.sv */
// ============================================================================
// tb
// Top of the SHA-1 hasher bench. It drives byte messages of many lengths,
// with empty messages, padding boundaries and stray unused commands, while
// both sides pause at random. A separate checker predicts and compares the
// digest words; this module drives the stimulus and gives the verdict.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block ignores this command code.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS    = 150;
    localparam int CALM_ITEMS     = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = sha1_pkg::CMD_ABSORB;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int digests_owed;
    int words_checked;
    int messages_closed;

    logic        calm    = 1'b0;
    logic        drained = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned stuck_cycles = 0;
    int unsigned words_sent    = 0;
    int unsigned payload_words = 0;

    sha1_byte_stream_hasher_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha1_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .digests_owed    (digests_owed),
        .words_checked   (words_checked),
        .messages_closed (messages_closed)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The digest side stalls in bursts of random length until the calm tail.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Give up when no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || drained || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offer one input word, maybe after a gap, and wait until it is taken.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (cmd != CMD_UNUSED) begin
            payload_words++;
        end
    endtask

    // A message of random bytes, closed either on its last byte or by a bare
    // finish, with stray unused commands sprinkled in when asked.
    task automatic send_message(input int unsigned len, input bit noisy);
        bit close_on_byte;
        close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned n = 0; n < len; n++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
            end
            if (close_on_byte && n == len - 1) begin
                send_word(sha1_pkg::CMD_ABSORB_FINISH, 8'($urandom_range(0, 255)));
            end else begin
                send_word(sha1_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
            end
        end
        if (!close_on_byte) begin
            send_word(sha1_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty message, then an ignored command.
        send_word(sha1_pkg::CMD_FINISH, 8'h00);
        send_word(CMD_UNUSED, 8'hFF);
        // The classic three-byte message.
        send_word(sha1_pkg::CMD_ABSORB, 8'h61);
        send_word(sha1_pkg::CMD_ABSORB, 8'h62);
        send_word(sha1_pkg::CMD_ABSORB_FINISH, 8'h63);
        // Single-byte messages at both byte extremes.
        send_word(sha1_pkg::CMD_ABSORB_FINISH, 8'h00);
        send_word(sha1_pkg::CMD_ABSORB_FINISH, 8'hFF);
        // An ignored command inside an otherwise empty message; the finish
        // carries a byte that must not be hashed.
        send_word(CMD_UNUSED, 8'h00);
        send_word(sha1_pkg::CMD_FINISH, 8'hFF);
        // Alternating bit patterns.
        send_word(sha1_pkg::CMD_ABSORB, 8'h55);
        send_word(sha1_pkg::CMD_ABSORB, 8'hAA);
        send_word(sha1_pkg::CMD_FINISH, 8'h00);

        // Padding that spills into a second block, and a message of exactly
        // one block.
        send_message(56, 1'b1);
        send_message(64, 1'b1);
        while (words_sent < TOTAL_ITEMS) begin
            if (words_sent >= TOTAL_ITEMS - CALM_ITEMS) begin
                calm <= 1'b1;
            end
            send_message($urandom_range(0, 15), 1'b1);
        end
        s_tvalid <= 1'b0;

        // Let the last digest drain, then let the bench settle.
        @(negedge aclk);
        while (digests_owed != 0) @(negedge aclk);
        drained <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d input words (%0d hashed or finishing, rest ignored commands).",
                 words_sent, payload_words);
        $display("Closed %0d messages, empty to 64 bytes; checked %0d digest words.",
                 messages_closed, words_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
